// ===== src/lzcd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzcd_pkg: shared types and constants for the LZ chunk decompressor
// Holds field widths, status codes and the copy-engine command structure.
// ----------------------------------------------------------------------------
package lzcd_pkg;

    localparam int unsigned WINDOW_SIZE_DEF = 65536;
    localparam int unsigned CFG_IDX_W       = 1;
    localparam int unsigned S_TDATA_W       = 8;
    localparam int unsigned M_TDATA_W       = 40;   // 4 bytes + count(3), padded
    localparam int unsigned COUNT_W         = 3;
    localparam int unsigned STATUS_W        = 3;
    localparam int unsigned LEN_W           = 7;    // copy length up to 67
    localparam int unsigned DIST_W          = 17;   // distance up to 65536

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DATA      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DONE_OK   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_DIST  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd4;

    // Copy request from the parser to the copy engine
    typedef struct packed {
        logic              start;
        logic [LEN_W-1:0]  len;
        logic [DIST_W-1:0] distance;
    } copy_cmd_t;

    // Copy engine status back to the parser
    typedef struct packed {
        logic busy;
        logic done;
    } copy_sts_t;

endpackage

// ===== src/lzcd_copy_engine.sv =====
// ----------------------------------------------------------------------------
// lzcd_copy_engine: history window and byte-serial copy unit
// Writes literal and copied bytes into the window one byte at a time, and
// gathers copied bytes into beats of up to four; a new copy starts only when idle.
// ----------------------------------------------------------------------------
module lzcd_copy_engine
    import lzcd_pkg::*;
#(
    parameter int unsigned WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  copy_cmd_t               cmd,
    input  logic                    lit_we,
    input  logic [7:0]              lit_byte,
    input  logic [31:0]             bytes_out,
    input  logic                    out_free,
    output copy_sts_t               sts,
    output logic                    beat_valid,
    output logic [31:0]             beat_bytes,
    output logic [COUNT_W-1:0]      beat_count,
    output logic                    beat_last,
    output logic                    byte_wr
);

    localparam int unsigned AW = $clog2(WINDOW_SIZE);

    logic [7:0]         mem [WINDOW_SIZE];
    logic [7:0]         rd_data_reg;

    typedef enum logic [3:0] {
        CE_IDLE = 4'b0001,
        CE_READ = 4'b0010,
        CE_WRT  = 4'b0100,
        CE_EMIT = 4'b1000
    } ce_state_t;

    ce_state_t          state_reg, state_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [AW-1:0]      src_reg, src_next;
    logic [AW-1:0]      dst_reg, dst_next;
    logic [31:0]        acc_reg, acc_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [7:0]         wdata;

    // Window port: literal writes or copy writes, read registered
    assign we    = lit_we || (state_reg == CE_WRT);
    assign waddr = lit_we ? bytes_out[AW-1:0] : dst_reg;
    assign wdata = lit_we ? lit_byte : rd_data_reg;
    assign byte_wr = (state_reg == CE_WRT);

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[src_reg];
    end

    // Sequence read, write, pack
    always_comb begin
        state_next = state_reg;
        left_next  = left_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            CE_IDLE: begin
                if (cmd.start) begin
                    left_next  = cmd.len;
                    src_next   = bytes_out[AW-1:0] - cmd.distance[AW-1:0];
                    dst_next   = bytes_out[AW-1:0];
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = CE_READ;
                end
            end
            CE_READ: state_next = CE_WRT;
            CE_WRT: begin
                acc_next = acc_reg | ({24'd0, rd_data_reg} << {cnt_reg[1:0], 3'b000});
                cnt_next = cnt_reg + 3'd1;
                left_next = left_reg - 7'd1;
                src_next = src_reg + 1'b1;
                dst_next = dst_reg + 1'b1;
                if (cnt_reg == 3'd3 || left_reg == 7'd1) begin
                    state_next = CE_EMIT;
                end else begin
                    state_next = CE_READ;
                end
            end
            CE_EMIT: begin
                if (out_free) begin
                    acc_next = '0;
                    cnt_next = '0;
                    state_next = (left_reg == '0) ? CE_IDLE : CE_READ;
                end
            end
            default: state_next = CE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CE_IDLE;
        end else begin
            state_reg <= state_next;
        end
        left_reg <= left_next;
        src_reg  <= src_next;
        dst_reg  <= dst_next;
        acc_reg  <= acc_next;
        cnt_reg  <= cnt_next;
    end

    assign beat_valid = (state_reg == CE_EMIT);
    assign beat_bytes = acc_reg;
    assign beat_count = cnt_reg;
    assign beat_last  = (left_reg == '0);
    assign sts.busy   = (state_reg != CE_IDLE);
    assign sts.done   = (state_reg == CE_EMIT) && out_free && (left_reg == '0);

endmodule

// ===== src/lz_chunk_decompressor.sv =====
// ----------------------------------------------------------------------------
// lz_chunk_decompressor: ADC-format decoder, one compressed byte per beat
// Parses headers, passes literals, runs copies through the window engine.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] data_byte, tuser mode
// m_axis    out  tdata: byte_a..byte_d[31:0], byte_count[34:32]; tuser status;
//                tlast last
// cfg       in   cfg_index (0 limit_enable, 1 output_limit), cfg_wdata
//
// During a copy each copied byte is read from the window and then written.
// Reset is synchronous on aresetn; the window holds no reset value.
// s_tready drops while a copy runs or the output register is full and m_tready is low.
// ----------------------------------------------------------------------------
module lz_chunk_decompressor
    import lzcd_pkg::*;
#(
    parameter int unsigned WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // [7:0] data_byte
    input  logic                  s_tuser,    // [0] mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // byte_a, byte_b, byte_c, byte_d, byte_count
    output logic [STATUS_W-1:0]   m_tuser,    // [2:0] status
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_wdata
);

    typedef enum logic [4:0] {
        PH_HEADER    = 5'b00001,
        PH_LITERAL   = 5'b00010,
        PH_LONG_HIGH = 5'b00100,
        PH_LONG_LOW  = 5'b01000,
        PH_SHORT_LOW = 5'b10000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         lit_left_reg, lit_left_next;
    logic [7:0]         hdr_reg, hdr_next;
    logic [7:0]         high_reg, high_next;
    logic [31:0]        bytes_out_reg, bytes_out_next;
    logic               full_reg, full_next;
    logic [STATUS_W-1:0] stop_reg, stop_next;
    logic               lim_en_reg;
    logic [31:0]        lim_reg;

    logic               ov_valid_reg, ov_valid_next;
    logic [31:0]        ov_bytes_reg, ov_bytes_next;
    logic [COUNT_W-1:0] ov_cnt_reg, ov_cnt_next;
    logic               ov_last_reg, ov_last_next;
    logic [STATUS_W-1:0] ov_st_reg, ov_st_next;

    copy_cmd_t          cmd;
    copy_sts_t          sts;
    logic               lit_we;
    logic               beat_valid, beat_last, byte_wr, out_free;
    logic [31:0]        beat_bytes;
    logic [COUNT_W-1:0] beat_count;
    logic               acc;
    logic               mode;
    logic [7:0]         b;
    logic [LEN_W-1:0]   clen;
    logic [DIST_W-1:0]  cdist;
    logic [31:0]        room;
    logic               over_lim;

    assign cfg_ready = 1'b1;
    assign out_free  = !ov_valid_reg || m_tready;
    assign s_tready  = out_free && !sts.busy;
    assign acc       = s_tvalid && s_tready;
    assign mode      = s_tuser;
    assign b         = s_tdata;

    // Copy length and distance from the saved header bytes and the current byte
    always_comb begin
        if (phase_reg == PH_LONG_LOW) begin
            clen  = {1'b0, hdr_reg[5:0]} + 7'd4;
            cdist = {1'b0, high_reg, b} + 17'd1;
        end else begin
            clen  = {3'd0, hdr_reg[5:2]} + 7'd3;
            cdist = {7'd0, hdr_reg[1:0], b} + 17'd1;
        end
    end

    assign room = lim_reg - bytes_out_reg;

    // Parse one beat
    always_comb begin
        phase_next     = phase_reg;
        lit_left_next  = lit_left_reg;
        hdr_next       = hdr_reg;
        high_next      = high_reg;
        bytes_out_next = bytes_out_reg;
        full_next      = full_reg;
        stop_next      = stop_reg;
        ov_valid_next  = ov_valid_reg && !m_tready;
        ov_bytes_next  = ov_bytes_reg;
        ov_cnt_next    = ov_cnt_reg;
        ov_last_next   = ov_last_reg;
        ov_st_next     = ov_st_reg;
        cmd            = '0;
        lit_we         = 1'b0;
        over_lim       = 1'b0;

        if (acc) begin
            ov_bytes_next = '0;
            ov_cnt_next   = '0;
            ov_last_next  = 1'b1;
            if (stop_reg != ST_DATA) begin
                if (mode) begin
                    ov_valid_next = 1'b1;
                    ov_st_next    = stop_reg;
                end
            end else if (mode) begin
                ov_valid_next = 1'b1;
                if (phase_reg != PH_HEADER) begin
                    stop_next = ST_TRUNCATED;
                end else if (lim_en_reg && bytes_out_reg != lim_reg) begin
                    stop_next = (bytes_out_reg < lim_reg) ? ST_TRUNCATED : ST_OVER;
                end else begin
                    stop_next = ST_DONE_OK;
                end
                ov_st_next = stop_next;
            end else begin
                case (phase_reg)
                    PH_HEADER: begin
                        if (lim_en_reg && bytes_out_reg > lim_reg) begin
                            stop_next = ST_OVER;
                        end else if (lim_en_reg && bytes_out_reg == lim_reg) begin
                            stop_next = ST_DATA;
                        end else if (b[7]) begin
                            if (lim_en_reg && ({24'd0, 1'b0, b[6:0]} + 32'd1) > room) begin
                                stop_next = ST_OVER;
                            end else begin
                                lit_left_next = {1'b0, b[6:0]} + 8'd1;
                                phase_next    = PH_LITERAL;
                            end
                        end else begin
                            hdr_next   = b;
                            phase_next = b[6] ? PH_LONG_HIGH : PH_SHORT_LOW;
                        end
                        if (stop_next != ST_DATA) begin
                            ov_valid_next = 1'b1;
                            ov_st_next    = stop_next;
                        end
                    end
                    PH_LITERAL: begin
                        lit_we         = 1'b1;
                        bytes_out_next = bytes_out_reg + 32'd1;
                        if (bytes_out_next >= WINDOW_SIZE) full_next = 1'b1;
                        lit_left_next  = lit_left_reg - 8'd1;
                        if (lit_left_next == 8'd0) phase_next = PH_HEADER;
                        ov_valid_next  = 1'b1;
                        ov_bytes_next  = {24'd0, b};
                        ov_cnt_next    = 3'd1;
                        ov_st_next     = ST_DATA;
                    end
                    PH_LONG_HIGH: begin
                        high_next  = b;
                        phase_next = PH_LONG_LOW;
                    end
                    default: begin
                        phase_next = PH_HEADER;
                        over_lim = lim_en_reg && ((bytes_out_reg > lim_reg) ||
                                   ({25'd0, clen} > room));
                        if (!full_reg && {15'd0, cdist} > bytes_out_reg) begin
                            stop_next = ST_BAD_DIST;
                        end else if (over_lim) begin
                            stop_next = ST_OVER;
                        end else begin
                            cmd.start    = 1'b1;
                            cmd.len      = clen;
                            cmd.distance = cdist;
                        end
                        if (stop_next != ST_DATA) begin
                            ov_valid_next = 1'b1;
                            ov_st_next    = stop_next;
                        end
                    end
                endcase
            end
        end

        // Count copied bytes and hand copy beats to the output register
        if (byte_wr) begin
            bytes_out_next = bytes_out_reg + 32'd1;
            if (bytes_out_next >= WINDOW_SIZE) full_next = 1'b1;
        end
        if (beat_valid && out_free) begin
            ov_valid_next = 1'b1;
            ov_bytes_next = beat_bytes;
            ov_cnt_next   = beat_count;
            ov_last_next  = beat_last;
            ov_st_next    = ST_DATA;
        end
    end

    // Hold control state and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            lit_left_reg  <= '0;
            hdr_reg       <= '0;
            high_reg      <= '0;
            bytes_out_reg <= '0;
            full_reg      <= 1'b0;
            stop_reg      <= ST_DATA;
            lim_en_reg    <= 1'b0;
            lim_reg       <= '0;
            ov_valid_reg  <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            lit_left_reg  <= lit_left_next;
            hdr_reg       <= hdr_next;
            high_reg      <= high_next;
            bytes_out_reg <= bytes_out_next;
            full_reg      <= full_next;
            stop_reg      <= stop_next;
            ov_valid_reg  <= ov_valid_next;
            if (cfg_valid && cfg_index == CFG_LIMIT_ENABLE) lim_en_reg <= cfg_wdata[0];
            if (cfg_valid && cfg_index == CFG_OUTPUT_LIMIT) lim_reg <= cfg_wdata;
        end
        ov_bytes_reg <= ov_bytes_next;
        ov_cnt_reg   <= ov_cnt_next;
        ov_last_reg  <= ov_last_next;
        ov_st_reg    <= ov_st_next;
    end

    lzcd_copy_engine #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_copy (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .lit_we     (lit_we),
        .lit_byte   (b),
        .bytes_out  (bytes_out_reg),
        .out_free   (out_free),
        .sts        (sts),
        .beat_valid (beat_valid),
        .beat_bytes (beat_bytes),
        .beat_count (beat_count),
        .beat_last  (beat_last),
        .byte_wr    (byte_wr)
    );

    assign m_tvalid = ov_valid_reg;
    assign m_tdata  = {5'd0, ov_cnt_reg, ov_bytes_reg};
    assign m_tuser  = ov_st_reg;
    assign m_tlast  = ov_last_reg;

endmodule

// ===== src/lzcd_checker.sv =====
// ----------------------------------------------------------------------------
// lzcd_checker: port-level checks for the LZ chunk decompressor
// Watches the stream ports and flags results that break the output format.
// ----------------------------------------------------------------------------
module lzcd_checker
    import lzcd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser,
    input logic                 m_tlast
);

    // Status beats carry no bytes and close the item
    a_status_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_DATA |-> m_tdata[34:32] == 3'd0 && m_tlast)
        else $error("status beat carries bytes");

    // Data beats carry one to four bytes
    a_data_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_DATA |-> m_tdata[34:32] != 3'd0 &&
        m_tdata[34:32] <= 3'd4)
        else $error("bad byte count");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // No new input while a result waits unaccepted
    a_no_accept_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

endmodule

bind lz_chunk_decompressor lzcd_checker u_lzcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== sim/lz_chunk_decompressor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_chunk_decompressor_test: self-checking bench for the ADC chunk decoder
// Feeds well-formed compressed streams with random content, a stalling
// receiver and repeated end marks; a local decoder model predicts every
// result beat, which the monitor checks field by field.
// ----------------------------------------------------------------------------
module lz_chunk_decompressor_test;
    import lzcd_pkg::*;

    typedef struct packed {
        logic       mode;
        logic [7:0] data;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]          b0, b1, b2, b3;
        logic [COUNT_W-1:0]  count;
        logic                last;
        logic [STATUS_W-1:0] status;
    } out_beat_t;

    typedef enum logic [2:0] {
        PH_HDR, PH_LIT, PH_LHIGH, PH_LLOW, PH_SLOW
    } phase_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    lz_chunk_decompressor dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Decoder model state
    logic [7:0]  hist [0:65535];
    phase_t      dec_phase;
    logic [7:0]  lit_left, hdr_saved, high_saved;
    logic [31:0] out_count;
    bit          hist_full;
    logic [2:0]  stop_status;
    bit          lim_en;
    logic [31:0] lim_val;

    in_beat_t  pending_in[$];
    out_beat_t expected_beats[$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        rx_hold = 1'b0;
    bit        in_done = 1'b0;
    bit        in_took = 1'b0;
    bit        out_took = 1'b0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic push_status(input logic [2:0] st);
        out_beat_t r;
        r = '0;
        r.last = 1'b1;
        r.status = st;
        stop_status = st;
        expected_beats.push_back(r);
    endtask

    function automatic bit beyond_limit(input logic [31:0] len);
        if (!lim_en) return 1'b0;
        return out_count > lim_val || len > lim_val - out_count;
    endfunction

    task automatic store_byte(input logic [7:0] v);
        hist[out_count[15:0]] = v;
        out_count = out_count + 32'd1;
        if (out_count >= 32'd65536) hist_full = 1'b1;
    endtask

    task automatic copy_bytes(input int len, input logic [31:0] distance);
        out_beat_t r;
        logic [7:0] v;
        int i;
        dec_phase = PH_HDR;
        if (!hist_full && distance > out_count) begin
            push_status(ST_BAD_DIST);
            return;
        end
        if (beyond_limit(len)) begin
            push_status(ST_OVER);
            return;
        end
        r = '0;
        for (i = 0; i < len; i++) begin
            v = hist[16'(out_count - distance)];
            store_byte(v);
            case (i % 4)
                0: r.b0 = v;
                1: r.b1 = v;
                2: r.b2 = v;
                default: r.b3 = v;
            endcase
            r.count = r.count + 3'd1;
            if (i % 4 == 3 || i == len - 1) begin
                r.last = (i == len - 1);
                expected_beats.push_back(r);
                r = '0;
            end
        end
    endtask

    // Work out the result beats one input beat causes
    task automatic decode_beat(input in_beat_t x);
        out_beat_t r;
        if (stop_status != ST_DATA) begin
            if (x.mode) push_status(stop_status);
            return;
        end
        if (x.mode) begin
            if (dec_phase != PH_HDR) push_status(ST_TRUNCATED);
            else if (lim_en && out_count != lim_val)
                push_status(out_count < lim_val ? ST_TRUNCATED : ST_OVER);
            else push_status(ST_DONE_OK);
            return;
        end
        case (dec_phase)
            PH_HDR: begin
                if (lim_en && out_count >= lim_val) begin
                    if (out_count != lim_val) push_status(ST_OVER);
                end else if (x.data[7]) begin
                    if (beyond_limit({25'd0, x.data[6:0]} + 1)) push_status(ST_OVER);
                    else begin
                        lit_left = {1'b0, x.data[6:0]} + 8'd1;
                        dec_phase = PH_LIT;
                    end
                end else begin
                    hdr_saved = x.data;
                    dec_phase = x.data[6] ? PH_LHIGH : PH_SLOW;
                end
            end
            PH_LIT: begin
                store_byte(x.data);
                lit_left = lit_left - 8'd1;
                if (lit_left == 0) dec_phase = PH_HDR;
                r = '0;
                r.b0 = x.data;
                r.count = 1;
                r.last = 1'b1;
                expected_beats.push_back(r);
            end
            PH_LHIGH: begin
                high_saved = x.data;
                dec_phase = PH_LLOW;
            end
            PH_LLOW: copy_bytes(hdr_saved[5:0] + 4, {15'd0, high_saved, x.data} + 1);
            default: copy_bytes(hdr_saved[5:2] + 3, {22'd0, hdr_saved[1:0], x.data} + 1);
        endcase
    endtask

    // Driver: wait a random gap per beat, then offer it until taken
    int tx_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_took) begin
                void'(pending_in.pop_front());
                tx_gap = $urandom_range(0, 14);
                if ($urandom_range(0, 3) == 0) tx_gap = 0;
            end
            if (s_tvalid && !in_took) begin
            end else if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_in.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_in[0].data;
                s_tuser <= pending_in[0].mode;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Prediction runs at the accepting edge
    always @(posedge aclk) begin
        in_took = aresetn && s_tvalid && s_tready;
        if (in_took) decode_beat('{s_tuser, s_tdata});
    end

    // Receiver stalls
    int rx_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_took) rx_gap = $urandom_range(0, 14);
            if (rx_hold) m_tready <= 1'b0;
            else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else m_tready <= 1'b1;
        end
    end

    // Monitor: compare each taken beat with the oldest prediction
    always @(posedge aclk) begin
        out_beat_t want;
        out_took = aresetn && m_tvalid && m_tready;
        if (out_took) begin
            if (expected_beats.size() == 0) report("unexpected beat", m_tdata, 0);
            else begin
                want = expected_beats.pop_front();
                if (m_tdata[7:0] !== want.b0) report("byte_a", m_tdata[7:0], want.b0);
                if (m_tdata[15:8] !== want.b1) report("byte_b", m_tdata[15:8], want.b1);
                if (m_tdata[23:16] !== want.b2) report("byte_c", m_tdata[23:16], want.b2);
                if (m_tdata[31:24] !== want.b3) report("byte_d", m_tdata[31:24], want.b3);
                if (m_tdata[34:32] !== want.count)
                    report("byte_count", m_tdata[34:32], want.count);
                if (m_tlast !== want.last) report("last", m_tlast, want.last);
                if (m_tuser !== want.status) report("status", m_tuser, want.status);
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || rx_hold || !aresetn)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_LIMIT_ENABLE) lim_en = val[0];
        else lim_val = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_in.size() > 0 || expected_beats.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic add_byte(input logic [7:0] b);
        pending_in.push_back('{1'b0, b});
    endtask

    task automatic add_end();
        pending_in.push_back('{1'b1, 8'h00});
    endtask

    // The decoder state has no reset-free restart, and once the block has
    // stopped it ignores further data; so all phases below continue one
    // stream, which ends only at the final end marks.
    // Well-formed stream: random literals and in-range copies
    task automatic add_stream(input int chunks, input int max_lit, output int produced);
        int n, k, len, distance, cnt;
        cnt = 0;
        for (k = 0; k < chunks; k++) begin
            if (cnt == 0 || $urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, max_lit);
                add_byte(8'(8'h80 | (n - 1)));
                repeat (n) add_byte(8'($urandom));
                cnt += n;
            end else if ($urandom_range(0, 1) == 0) begin
                len = $urandom_range(3, 18);
                distance = $urandom_range(1, cnt < 1024 ? cnt : 1024);
                add_byte({2'b00, 4'(len - 3), 2'((distance - 1) >> 8)});
                add_byte(8'(distance - 1));
                cnt += len;
            end else begin
                len = $urandom_range(4, 67);
                distance = $urandom_range(1, cnt);
                add_byte({2'b01, 6'(len - 4)});
                add_byte(8'((distance - 1) >> 8));
                add_byte(8'(distance - 1));
                cnt += len;
            end
        end
        produced = cnt;
    endtask

    initial begin
        int n, k;
        dec_phase = PH_HDR;
        lit_left = 0; hdr_saved = 0; high_saved = 0;
        out_count = 0; hist_full = 0; stop_status = ST_DATA;
        lim_en = 0; lim_val = 0;
        for (k = 0; k < 65536; k++) hist[k] = 8'h00;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        reg_write(CFG_LIMIT_ENABLE, 32'd0);
        reg_write(CFG_OUTPUT_LIMIT, 32'hFFFF_FFFF);

        // Directed: extreme literals, short and long copies, overlap
        add_byte(8'h80); add_byte(8'h00);
        add_byte(8'h81); add_byte(8'hFF); add_byte(8'hA5);
        add_byte(8'h3C); add_byte(8'h00);          // short, len 18, dist 1
        add_byte(8'h00); add_byte(8'h02);          // short, len 3, dist 3
        add_byte(8'h7F); add_byte(8'h00); add_byte(8'h00); // long, len 67, dist 1
        add_byte(8'h40); add_byte(8'h00); add_byte(8'h55); // long, len 4, dist 86
        drain();

        // Pressure: receiver holds off while the sender keeps offering
        add_stream(8, 24, n);
        rx_hold = 1'b1;
        repeat (400) @(posedge aclk);
        rx_hold = 1'b0;
        drain();

        // Bulk random well-formed content, then a clean end
        add_stream(10, 16, n);
        repeat (30) add_byte(8'(8'h80 | $urandom_range(0, 2)));
        drain();
        while (dec_phase != PH_HDR) begin
            add_byte(8'($urandom));
            drain();
        end
        add_end();
        add_end();
        add_byte(8'($urandom));                    // ignored once stopped
        add_end();
        drain();

        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
